>>> rtl/core/pvc_pkg.sv
// Package for the velocity-form PI controller.
// Shared unit opcodes, request struct, register indexes and constants.
// No dependencies.
`default_nettype none
package pvc_pkg;

    localparam int DataW = 32;
    localparam int MagW  = 31;
    localparam int WideW = 64;
    localparam int DivW  = 128;
    localparam int CntW  = 7;

    localparam logic [MagW-1:0] ITIME_MIN_RAW = 31'd655;   // 0.01 s
    localparam logic [WideW-1:0] GAIN_PCT     = 64'd100;
    // x / 20 == (x * ceil(2^36 / 20)) >> 36 for any x below 2^31 (5 percent of span)
    localparam logic [WideW-1:0] LIMIT_RECIP  = 64'd3435973837;
    localparam int               LIMIT_SHIFT  = 36;
    localparam int               FRAC_BITS    = 16;

    typedef enum logic [2:0] {
        REG_ENABLE    = 3'd0,
        REG_SETPOINT  = 3'd1,
        REG_PROP_BAND = 3'd2,
        REG_ITIME     = 3'd3,
        REG_DIRECT    = 3'd4,
        REG_PV_SPAN   = 3'd5,
        REG_MV_SPAN   = 3'd6,
        REG_FTIME     = 3'd7
    } cfg_idx_t;

    typedef enum logic [0:0] {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } alu_op_t;

    // MUL: opa[63:0] * opb. DIV: min(opa / opb, cap).
    typedef struct packed {
        alu_op_t           op;
        logic [DivW-1:0]   opa;
        logic [WideW-1:0]  opb;
        logic [WideW-1:0]  cap;
    } alu_req_t;

endpackage
`default_nettype wire

>>> rtl/core/pi_velocity_controller_top.sv
// PI velocity controller top: config registers, sequencer, shared ALU.
// Disabled: result valid in the cycle after acceptance. Enabled: optional lag filter,
// error, optional integral term, gain, limit, band and change multiplies, capped divide.
// One item at a time; the next item is accepted once the sequencer is idle and the
// output register is free or being read. Reset: synchronous active-low aresetn; filter
// state -1, last error 0, registers to their defaults. Depends on pvc_pkg, pvc_alu.
`default_nettype none
module pi_velocity_controller_top import pvc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // measured_value[31:0], time_step[62:32], present_output[93:63]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // filtered_measure[31:0], new_output[62:32],
                                        // output_change[94:63]
    output logic             m_tuser,   // active[0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_FMUL1 = 12'b000000000010,
        ST_FMUL2 = 12'b000000000100,
        ST_FDIV  = 12'b000000001000,
        ST_ERR   = 12'b000000010000,
        ST_IMUL  = 12'b000000100000,
        ST_IDIV  = 12'b000001000000,
        ST_KMUL  = 12'b000010000000,
        ST_LDIV  = 12'b000100000000,
        ST_DMUL  = 12'b001000000000,
        ST_CMUL  = 12'b010000000000,
        ST_CDIV  = 12'b100000000000
    } state_t;

    // configuration
    logic                   enable_reg, direct_reg;
    logic signed [DataW-1:0] setpoint_reg;
    logic [MagW-1:0]        pb_reg, it_reg, pvs_reg, mvs_reg, ft_reg;

    // sequencer state
    state_t                 state_reg, state_next;
    logic                   launched_reg, launched_next;
    logic                   done_seen_reg, done_seen_next;
    logic signed [DataW-1:0] fv_reg, fv_next;
    logic signed [DataW-1:0] lerr_reg, lerr_next;
    logic signed [DataW-1:0] pv_reg, pv_next;
    logic [MagW-1:0]        dt_reg, dt_next, pres_reg, pres_next;
    logic [WideW-1:0]       t1_reg, t1_next;
    logic                   nneg_reg, nneg_next;
    logic signed [DataW-1:0] err_reg, err_next;
    logic signed [WideW-1:0] term_reg, term_next;
    logic [WideW-1:0]       k_reg, k_next, den_reg, den_next, lim_reg, lim_next;

    // output register
    logic                   ovalid_reg, ovalid_next;
    logic [95:0]            odata_reg, odata_next;

    alu_req_t               req;
    logic                   alu_start, alu_done;
    logic [DivW-1:0]        alu_res;
    logic                   arith;

    logic [DataW:0]         pv_mag, err_mag;
    logic signed [WideW-1:0] n_sum;
    logic [DataW:0]         e33, d33;
    logic signed [DataW-1:0] e_sat;
    logic [WideW-1:0]       term_mag;
    logic [DataW-1:0]       fq, chg_mag, change;
    logic                   cneg;
    logic signed [DataW:0]  mv33;
    logic [MagW-1:0]        mv_out;
    logic [MagW-1:0]        pvs_eff, pb_eff;

    pvc_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (alu_start),
        .req     (req),
        .done    (alu_done),
        .res     (alu_res)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) && !launched_reg && (!ovalid_reg || m_tready);
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = {1'b0, odata_reg[94:0]};
    assign m_tuser   = odata_reg[95];

    assign arith     = (state_reg != ST_IDLE) && (state_reg != ST_ERR);
    assign alu_start = arith && !launched_reg;

    assign pv_mag   = pv_reg[DataW-1] ? ((DataW+1)'(0) - {pv_reg[DataW-1], pv_reg})
                                      : {1'b0, pv_reg};
    assign err_mag  = err_reg[DataW-1] ? ((DataW+1)'(0) - {err_reg[DataW-1], err_reg})
                                       : {1'b0, err_reg};
    assign term_mag = term_reg[WideW-1] ? (WideW'(0) - term_reg) : term_reg;
    assign pvs_eff  = (pvs_reg == '0) ? MagW'(1) : pvs_reg;
    assign pb_eff   = (pb_reg == '0) ? MagW'(1) : pb_reg;

    // request to the shared unit per state
    always_comb begin
        req.op  = OP_MUL;
        req.opa = '0;
        req.opb = '0;
        req.cap = '1;
        unique case (state_reg)
            ST_FMUL1: begin
                req.opa = {{(DivW-DataW){1'b0}}, fv_reg};
                req.opb = {{(WideW-MagW){1'b0}}, ft_reg};
            end
            ST_FMUL2: begin
                req.opa = {{(DivW-DataW-1){1'b0}}, pv_mag};
                req.opb = {{(WideW-MagW){1'b0}}, dt_reg};
            end
            ST_FDIV: begin
                req.op  = OP_DIV;
                req.opa = {{(DivW-WideW){1'b0}}, t1_reg};
                req.opb = {{(WideW-MagW){1'b0}}, ft_reg} + {{(WideW-MagW){1'b0}}, dt_reg};
            end
            ST_IMUL: begin
                req.opa = {{(DivW-DataW-1){1'b0}}, err_mag};
                req.opb = {{(WideW-MagW){1'b0}}, dt_reg};
            end
            ST_IDIV: begin
                req.op  = OP_DIV;
                req.opa = alu_res;    // product still held by the unit
                req.opb = {{(WideW-MagW){1'b0}}, it_reg};
            end
            ST_KMUL: begin
                req.opa = {{(DivW-MagW){1'b0}}, mvs_reg};
                req.opb = GAIN_PCT;
            end
            ST_LDIV: begin
                // span / 20 as a reciprocal multiply
                req.opa = {{(DivW-MagW){1'b0}}, mvs_reg};
                req.opb = LIMIT_RECIP;
            end
            ST_DMUL: begin
                req.opa = {{(DivW-MagW){1'b0}}, pvs_eff};
                req.opb = {{(WideW-MagW){1'b0}}, pb_eff};
            end
            ST_CMUL: begin
                req.opa = {{(DivW-WideW){1'b0}}, term_mag};
                req.opb = k_reg;
            end
            ST_CDIV: begin
                req.op  = OP_DIV;
                req.opa = {alu_res[DivW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
                req.opb = den_reg;
                req.cap = lim_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        launched_next  = launched_reg;
        done_seen_next = done_seen_reg;
        fv_next        = fv_reg;
        lerr_next      = lerr_reg;
        pv_next        = pv_reg;
        dt_next        = dt_reg;
        pres_next      = pres_reg;
        t1_next        = t1_reg;
        nneg_next      = nneg_reg;
        err_next       = err_reg;
        term_next      = term_reg;
        k_next         = k_reg;
        den_next       = den_reg;
        lim_next       = lim_reg;
        ovalid_next    = ovalid_reg;
        odata_next     = odata_reg;

        n_sum   = pv_reg[DataW-1] ? ($signed(t1_reg) - $signed(alu_res[WideW-1:0]))
                                  : ($signed(t1_reg) + $signed(alu_res[WideW-1:0]));
        fq      = alu_res[DataW-1:0];
        e33     = {fv_reg[DataW-1], fv_reg} - {setpoint_reg[DataW-1], setpoint_reg};
        e_sat   = (e33[DataW] != e33[DataW-1])
                ? (e33[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}})
                : e33[DataW-1:0];
        d33     = {e_sat[DataW-1], e_sat} - {lerr_reg[DataW-1], lerr_reg};
        chg_mag = alu_res[DataW-1:0];
        cneg    = term_reg[WideW-1] ^ direct_reg;
        change  = cneg ? (DataW'(0) - chg_mag) : chg_mag;
        mv33    = $signed({2'b00, pres_reg}) + $signed({change[DataW-1], change});
        if (mv33[DataW])
            mv_out = '0;
        else if (mv33 > $signed({2'b00, mvs_reg}))
            mv_out = mvs_reg;
        else
            mv_out = mv33[MagW-1:0];

        if (ovalid_reg && m_tready)
            ovalid_next = 1'b0;

        if (alu_start)
            launched_next = 1'b1;
        if (alu_done)
            launched_next = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    pv_next   = s_tdata[31:0];
                    dt_next   = s_tdata[62:32];
                    pres_next = s_tdata[93:63];
                    if (!enable_reg) begin
                        ovalid_next = 1'b1;
                        odata_next  = {1'b0, {DataW{1'b0}}, s_tdata[93:63], fv_reg};
                    end else if (fv_reg[DataW-1] || (ft_reg == '0)) begin
                        fv_next    = s_tdata[31:0];
                        state_next = ST_ERR;
                    end else begin
                        state_next = ST_FMUL1;
                    end
                end
            end
            ST_FMUL1: begin
                if (alu_done) begin
                    t1_next    = alu_res[WideW-1:0];
                    state_next = ST_FMUL2;
                end
            end
            ST_FMUL2: begin
                if (alu_done) begin
                    nneg_next  = n_sum[WideW-1];
                    t1_next    = n_sum[WideW-1] ? (WideW'(0) - n_sum) : n_sum;
                    state_next = ST_FDIV;
                end
            end
            ST_FDIV: begin
                if (alu_done) begin
                    fv_next    = nneg_reg ? (DataW'(0) - fq) : fq;
                    state_next = ST_ERR;
                end
            end
            ST_ERR: begin
                err_next   = e_sat;
                lerr_next  = e_sat;
                term_next  = {{(WideW-DataW-1){d33[DataW]}}, d33};
                state_next = (it_reg > ITIME_MIN_RAW) ? ST_IMUL : ST_KMUL;
            end
            ST_IMUL: begin
                if (alu_done)
                    state_next = ST_IDIV;
            end
            ST_IDIV: begin
                if (alu_done) begin
                    term_next  = err_reg[DataW-1] ? (term_reg - $signed(alu_res[WideW-1:0]))
                                                  : (term_reg + $signed(alu_res[WideW-1:0]));
                    state_next = ST_KMUL;
                end
            end
            ST_KMUL: begin
                if (alu_done) begin
                    k_next     = alu_res[WideW-1:0];
                    state_next = ST_LDIV;
                end
            end
            ST_LDIV: begin
                if (alu_done) begin
                    lim_next   = alu_res[LIMIT_SHIFT+WideW-1:LIMIT_SHIFT];
                    state_next = ST_DMUL;
                end
            end
            ST_DMUL: begin
                if (alu_done) begin
                    den_next   = alu_res[WideW-1:0];
                    state_next = ST_CMUL;
                end
            end
            ST_CMUL: begin
                if (alu_done)
                    state_next = ST_CDIV;
            end
            ST_CDIV: begin
                // quotient stays in the unit until the output register is free
                if (alu_done || done_seen_reg) begin
                    if (!ovalid_reg || m_tready) begin
                        ovalid_next    = 1'b1;
                        odata_next     = {1'b1, change, mv_out, fv_reg};
                        launched_next  = 1'b0;
                        done_seen_next = 1'b0;
                        state_next     = ST_IDLE;
                    end else begin
                        launched_next  = 1'b1;
                        done_seen_next = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            launched_reg  <= 1'b0;
            done_seen_reg <= 1'b0;
            ovalid_reg    <= 1'b0;
            fv_reg        <= '1;
            lerr_reg      <= '0;
            enable_reg    <= 1'b0;
            setpoint_reg  <= '0;
            pb_reg        <= 31'd65536000;
            it_reg        <= 31'd3276800;
            direct_reg    <= 1'b1;
            pvs_reg       <= 31'd655360;
            mvs_reg       <= 31'd6553600;
            ft_reg        <= '0;
        end else begin
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            done_seen_reg <= done_seen_next;
            ovalid_reg    <= ovalid_next;
            fv_reg        <= fv_next;
            lerr_reg      <= lerr_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_idx_t'(cfg_index))
                    REG_ENABLE:    enable_reg   <= cfg_data[0];
                    REG_SETPOINT:  setpoint_reg <= cfg_data;
                    REG_PROP_BAND: pb_reg       <= cfg_data[MagW-1:0];
                    REG_ITIME:     it_reg       <= cfg_data[MagW-1:0];
                    REG_DIRECT:    direct_reg   <= cfg_data[0];
                    REG_PV_SPAN:   pvs_reg      <= cfg_data[MagW-1:0];
                    REG_MV_SPAN:   mvs_reg      <= cfg_data[MagW-1:0];
                    REG_FTIME:     ft_reg       <= cfg_data[MagW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        pv_reg    <= pv_next;
        dt_reg    <= dt_next;
        pres_reg  <= pres_next;
        t1_reg    <= t1_next;
        nneg_reg  <= nneg_next;
        err_reg   <= err_next;
        term_reg  <= term_next;
        k_reg     <= k_next;
        den_reg   <= den_next;
        lim_reg   <= lim_next;
        odata_reg <= odata_next;
    end

endmodule
`default_nettype wire

>>> rtl/core/pvc_alu.sv
// Shared bit-serial multiply / capped restoring divide unit.
// MUL runs 64 steps, DIV 128; start loads the operands and done is registered. Depends on pvc_pkg.
`default_nettype none
module pvc_alu import pvc_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  alu_req_t              req,
    output logic                  done,
    output logic [DivW-1:0]       res
);

    alu_op_t            op_reg, op_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CntW-1:0]    cnt_reg, cnt_next;
    logic [DivW-1:0]    acc_reg, acc_next;
    logic [WideW-1:0]   b_reg, b_next;
    logic [WideW-1:0]   rem_reg, rem_next;
    logic [WideW-1:0]   q_reg, q_next;
    logic [WideW-1:0]   cap_reg, cap_next;
    logic               over_reg, over_next;

    logic [WideW:0]     sum;
    logic [WideW:0]     trial;
    logic [WideW-1:0]   q_shift;
    logic               last;

    always_comb begin
        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cap_next  = cap_reg;
        over_next = over_reg;
        sum       = {1'b0, acc_reg[DivW-1:WideW]} + (acc_reg[0] ? {1'b0, b_reg} : '0);
        trial     = {rem_reg, acc_reg[DivW-1]};
        q_shift   = '0;
        last      = (op_reg == OP_MUL) ? (cnt_reg == CntW'(WideW - 1)) : (&cnt_reg);
        if (start) begin
            op_next   = req.op;
            busy_next = 1'b1;
            cnt_next  = '0;
            b_next    = req.opb;
            cap_next  = req.cap;
            rem_next  = '0;
            q_next    = '0;
            over_next = 1'b0;
            acc_next  = (req.op == OP_MUL) ? {{WideW{1'b0}}, req.opa[WideW-1:0]} : req.opa;
        end else if (busy_reg) begin
            unique case (op_reg)
                OP_MUL: begin
                    acc_next = {sum, acc_reg[WideW-1:1]};
                end
                OP_DIV: begin
                    acc_next = {acc_reg[DivW-2:0], 1'b0};
                    if (trial >= {1'b0, b_reg}) begin
                        rem_next = WideW'(trial - {1'b0, b_reg});
                        q_shift  = {q_reg[WideW-2:0], 1'b1};
                    end else begin
                        rem_next = trial[WideW-1:0];
                        q_shift  = {q_reg[WideW-2:0], 1'b0};
                    end
                    q_next    = q_shift;
                    // quotient prefixes only grow, so once past the cap it stays there
                    over_next = over_reg | q_reg[WideW-1] | (q_shift > cap_reg);
                end
                default: ;
            endcase
            cnt_next = cnt_reg + 1'b1;
            if (last) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        b_reg    <= b_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        cap_reg  <= cap_next;
        over_reg <= over_next;
    end

    assign done = done_reg;
    assign res  = (op_reg == OP_MUL) ? acc_reg
                : {{WideW{1'b0}}, (over_reg ? cap_reg : q_reg)};

endmodule
`default_nettype wire
